// ===== rtl/cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// cbr_pkg
// Types, register codes and helpers shared by the collision response block.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_GAIN   = 2'd1;

  localparam int ISQRT_STAGES = 32;
  localparam int RAD_W        = 64;
  localparam int SQ_W         = 63;
  localparam int OUT_SUM_W    = 46;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic signed [31:0] first_vel_z;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic signed [31:0] second_vel_z;
    logic [30:0]        first_mass;
    logic [30:0]        second_mass;
  } cbr_item_t;

  typedef struct packed {
    logic signed [31:0] new_first_vel_x;
    logic signed [31:0] new_first_vel_y;
    logic signed [31:0] new_first_vel_z;
    logic signed [31:0] new_second_vel_x;
    logic signed [31:0] new_second_vel_y;
    logic signed [31:0] new_second_vel_z;
    logic               degenerate;
  } cbr_result_t;

  typedef struct packed {
    vec3_t v1;
    vec3_t v2;
    logic  degen;
  } cbr_pay_t;

  typedef struct packed {
    cbr_pay_t    pay;
    vec3_t       mag;
    logic [2:0]  sgn;
    logic [30:0] first_mass;
    logic [30:0] second_mass;
    logic [31:0] tot;
  } cbr_side_a_t;

  typedef struct packed {
    cbr_pay_t   pay;
    logic [2:0] sgn;
    logic       tot_zero;
  } cbr_side_b_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [OUT_SUM_W-1:0] x);
    logic [31:0] res;
    if (x > $signed(OUT_SUM_W'(32'h7FFF_FFFF))) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -$signed(OUT_SUM_W'(33'h0_8000_0000))) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/cbr_delay.sv =====
// ----------------------------------------------------------------------------
// cbr_delay
// Shift line that carries side data next to a pipelined unit, one register
// per stage, each stage with its own load enable.
// ----------------------------------------------------------------------------
module cbr_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic [D-1:0] en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [D];

  for (genvar s = 0; s < D; s++) begin : g_stage
    logic [W-1:0] src;
    if (s == 0) begin : g_first
      assign src = din;
    end else begin : g_next
      assign src = line[s-1];
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        line[s] <= src;
      end
    end
  end

  assign dout = line[D-1];

endmodule

// ===== rtl/cbr_isqrt.sv =====
// ----------------------------------------------------------------------------
// cbr_isqrt
// Pipelined integer square root, floor(sqrt(radicand)), one result bit per
// stage.
// ----------------------------------------------------------------------------
module cbr_isqrt (
  input  logic                              clk,
  input  logic [cbr_pkg::ISQRT_STAGES-1:0]  en,
  input  logic [cbr_pkg::RAD_W-1:0]         radicand,
  output logic [cbr_pkg::ISQRT_STAGES-1:0]  root
);
  import cbr_pkg::*;

  localparam int STG   = ISQRT_STAGES;
  localparam int REM_W = STG + 3;

  logic [REM_W-1:0] rem  [STG];
  logic [STG-1:0]   rt   [STG];
  logic [RAD_W-1:0] rest [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [REM_W-1:0] rem_src;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [STG-1:0]   rt_src;
    logic [RAD_W-1:0] rest_src;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_src  = '0;
      assign rt_src   = '0;
      assign rest_src = radicand;
    end else begin : g_next
      assign rem_src  = rem[s-1];
      assign rt_src   = rt[s-1];
      assign rest_src = rest[s-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_src[REM_W-3:0], rest_src[RAD_W-1 -: 2]};
    assign trial  = REM_W'({rt_src, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s]  <= ge ? rem_sh - trial : rem_sh;
        rt[s]   <= {rt_src[STG-2:0], ge};
        rest[s] <= {rest_src[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[STG-1];

endmodule

// ===== rtl/cbr_div.sv =====
// ----------------------------------------------------------------------------
// cbr_div
// Pipelined restoring divider for num * 2^(QW-1) / den with num <= den, so
// the quotient fits QW bits. One quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module cbr_div #(
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW:0]   rem  [QW];
  logic [QW-1:0] q    [QW];
  logic [DW-1:0] dvs  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   r_src;
    logic [DW:0]   r_after;
    logic [QW-1:0] q_src;
    logic [DW-1:0] d_src;
    logic          ge;

    if (s == 0) begin : g_first
      assign r_src = {1'b0, num};
      assign q_src = '0;
      assign d_src = den;
    end else begin : g_next
      assign r_src = rem[s-1];
      assign q_src = q[s-1];
      assign d_src = dvs[s-1];
    end

    assign ge      = r_src >= {1'b0, d_src};
    assign r_after = ge ? r_src - {1'b0, d_src} : r_src;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s] <= {r_after[DW-1:0], 1'b0};
        q[s]   <= {q_src[QW-2:0], ge};
        dvs[s] <= d_src;
      end
    end
  end

  assign quo = q[QW-1];

endmodule

// ===== rtl/two_body_collision_response.sv =====
// ----------------------------------------------------------------------------
// two_body_collision_response
// Impulse collision response with restitution and push-out for one body
// pair per beat, fixed point with FRAC_BITS fraction bits.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   item     | item_valid/item_stall  | cbr_item_t pair
//   result   | result_valid/result_stall | cbr_result_t velocities
//   cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One pair per cycle is accepted while result_stall is low or a stage is empty.
// The 32-stage square root and the FRAC_BITS+1 stage dividers set the depth.
// Reset clears all valid bits and loads restitution 1.0 and push gain 0.25.
// A stalled result holds in the output register while the stages behind it
// keep accepting until every stage is full.
// ----------------------------------------------------------------------------
module two_body_collision_response #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  cbr_pkg::cbr_item_t              item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output cbr_pkg::cbr_result_t            result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbr_pkg::CFG_W-1:0]       cfg_data
);
  import cbr_pkg::*;

  localparam int QW   = FRAC_BITS + 1;
  localparam int SQ0  = 2;
  localparam int DV0  = SQ0 + ISQRT_STAGES;
  localparam int D0   = DV0 + QW;
  localparam int L    = D0 + 7;

  localparam int NW   = FRAC_BITS + 2;
  localparam int CW   = FRAC_BITS + 3;
  localparam int PW   = FRAC_BITS + 35;
  localparam int SUMW = FRAC_BITS + 37;
  localparam int JPW  = FRAC_BITS + 40;
  localparam int RPW  = FRAC_BITS + 42;
  localparam int NPW  = FRAC_BITS + 44;
  localparam int GPW  = FRAC_BITS + 20;

  localparam logic [NW-1:0] W_HALF = NW'(64'd1 << (FRAC_BITS - 1));

  // Configuration registers.
  logic [CFG_W-1:0]       restitution;
  logic [CFG_W-1:0]       push_gain;
  logic signed [CW-1:0]   coef;
  logic signed [CFG_W:0]  gain;
  logic [31:0]            e_one;
  logic [31:0]            e_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= CFG_W'(64'd1 << FRAC_BITS);
      push_gain   <= CFG_W'(64'd1 << (FRAC_BITS - 2));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESTITUTION: restitution <= cfg_data;
        REG_PUSH_GAIN:   push_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Restitution above one is clamped, so the impulse scale stays within 2.0.
  always_comb begin
    e_one = 32'd1 << FRAC_BITS;
    e_val = (32'(restitution) > e_one) ? e_one : 32'(restitution);
  end

  always_ff @(posedge clk) begin
    coef <= $signed(CW'(e_one + e_val));
    gain <= $signed({1'b0, push_gain});
  end

  // Stage occupancy and load enables. A stage may load when it is empty or
  // some stage at or after it has a hole, or the output is being taken.
  logic [L-1:0] vld;
  logic [L-1:0] rdy;

  always_comb begin
    for (int k = 0; k < L; k++) begin
      rdy[k] = !result_stall || (((~vld) & ({L{1'b1}} << k)) != '0);
    end
  end

  assign item_stall   = rst || !rdy[0];
  assign result_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < L; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage A: squares of the offset.
  cbr_item_t   a_item;
  logic [SQ_W-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_item <= item;
      sq[0]  <= SQ_W'(64'(item.offset_x) * 64'(item.offset_x));
      sq[1]  <= SQ_W'(64'(item.offset_y) * 64'(item.offset_y));
      sq[2]  <= SQ_W'(64'(item.offset_z) * 64'(item.offset_z));
    end
  end

  // Stage B: squared length, magnitudes and mass sum.
  logic [RAD_W-1:0] sumsq;
  cbr_side_a_t      side_a_next;
  cbr_side_a_t      b_side;

  always_comb begin
    side_a_next.pay.v1    = {a_item.first_vel_z, a_item.first_vel_y, a_item.first_vel_x};
    side_a_next.pay.v2    = {a_item.second_vel_z, a_item.second_vel_y, a_item.second_vel_x};
    side_a_next.pay.degen = (a_item.offset_x == '0) && (a_item.offset_y == '0)
                            && (a_item.offset_z == '0);
    side_a_next.mag[0]    = abs32(a_item.offset_x);
    side_a_next.mag[1]    = abs32(a_item.offset_y);
    side_a_next.mag[2]    = abs32(a_item.offset_z);
    side_a_next.sgn       = {a_item.offset_z[31], a_item.offset_y[31], a_item.offset_x[31]};
    side_a_next.first_mass  = a_item.first_mass;
    side_a_next.second_mass = a_item.second_mass;
    side_a_next.tot       = 32'(a_item.first_mass) + 32'(a_item.second_mass);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sumsq  <= RAD_W'(sq[0]) + RAD_W'(sq[1]) + RAD_W'(sq[2]);
      b_side <= side_a_next;
    end
  end

  // Length of the offset.
  logic [ISQRT_STAGES-1:0] len;
  cbr_side_a_t             c_side;

  cbr_isqrt u_isqrt (
    .clk      (clk),
    .en       (rdy[SQ0 +: ISQRT_STAGES]),
    .radicand (sumsq),
    .root     (len)
  );

  cbr_delay #(
    .W ($bits(cbr_side_a_t)),
    .D (ISQRT_STAGES)
  ) u_dly_a (
    .clk  (clk),
    .en   (rdy[SQ0 +: ISQRT_STAGES]),
    .din  (b_side),
    .dout (c_side)
  );

  // Normal magnitudes and mass weights.
  logic [QW-1:0] qn [3];
  logic [QW-1:0] qw1;
  logic [QW-1:0] qw2;
  cbr_side_b_t   side_b_next;
  cbr_side_b_t   d_side;

  for (genvar i = 0; i < 3; i++) begin : g_norm
    cbr_div #(
      .DW (32),
      .QW (QW)
    ) u_div_n (
      .clk (clk),
      .en  (rdy[DV0 +: QW]),
      .num (c_side.mag[i]),
      .den (len),
      .quo (qn[i])
    );
  end

  cbr_div #(
    .DW (32),
    .QW (QW)
  ) u_div_w1 (
    .clk (clk),
    .en  (rdy[DV0 +: QW]),
    .num ({1'b0, c_side.second_mass}),
    .den (c_side.tot),
    .quo (qw1)
  );

  cbr_div #(
    .DW (32),
    .QW (QW)
  ) u_div_w2 (
    .clk (clk),
    .en  (rdy[DV0 +: QW]),
    .num ({1'b0, c_side.first_mass}),
    .den (c_side.tot),
    .quo (qw2)
  );

  always_comb begin
    side_b_next.pay      = c_side.pay;
    side_b_next.sgn      = c_side.sgn;
    side_b_next.tot_zero = c_side.tot == '0;
  end

  cbr_delay #(
    .W ($bits(cbr_side_b_t)),
    .D (QW)
  ) u_dly_b (
    .clk  (clk),
    .en   (rdy[DV0 +: QW]),
    .din  (side_b_next),
    .dout (d_side)
  );

  // Back end registers.
  logic signed [NW-1:0]   n0 [3], n1 [3], n2 [3], n3 [3], n4 [3];
  logic signed [NW-1:0]   w1_0, w1_1, w1_2, w1_3;
  logic signed [NW-1:0]   w2_0, w2_1, w2_2, w2_3;
  cbr_pay_t               pay0, pay1, pay2, pay3, pay4, pay5;
  logic signed [PW-1:0]   prod [3];
  logic signed [36:0]     dot2;
  logic signed [39:0]     j3;
  logic signed [41:0]     r1_4, r2_4;
  logic signed [43:0]     rn1 [3], rn2 [3];
  logic signed [19:0]     push [3];

  // Combinational products between them.
  logic signed [32:0]     diff [3];
  logic signed [PW-1:0]   prod_next [3];
  logic signed [SUMW-1:0] dsum;
  logic signed [JPW-1:0]  jp;
  logic signed [RPW-1:0]  rp1, rp2;
  logic signed [NPW-1:0]  np1 [3], np2 [3];
  logic signed [GPW-1:0]  gp [3];
  logic [31:0]            nv1 [3], nv2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]      = 33'($signed(pay0.v1[i])) - 33'($signed(pay0.v2[i]));
      prod_next[i] = PW'(diff[i]) * PW'(n0[i]);
    end
    dsum = SUMW'(prod[0]) + SUMW'(prod[1]) + SUMW'(prod[2]);
    jp   = JPW'(dot2) * JPW'(coef);
    rp1  = RPW'(j3) * RPW'(w1_3);
    rp2  = RPW'(j3) * RPW'(w2_3);
    for (int i = 0; i < 3; i++) begin
      np1[i] = NPW'(r1_4) * NPW'(n4[i]);
      np2[i] = NPW'(r2_4) * NPW'(n4[i]);
      gp[i]  = GPW'(gain) * GPW'(n4[i]);
    end
    for (int i = 0; i < 3; i++) begin
      nv1[i] = sat32(OUT_SUM_W'($signed(pay5.v1[i])) - OUT_SUM_W'(rn1[i])
                     - OUT_SUM_W'(push[i]));
      nv2[i] = sat32(OUT_SUM_W'($signed(pay5.v2[i])) + OUT_SUM_W'(rn2[i])
                     + OUT_SUM_W'(push[i]));
      if (pay5.degen) begin
        nv1[i] = pay5.v1[i];
        nv2[i] = pay5.v2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[D0]) begin
      for (int i = 0; i < 3; i++) begin
        n0[i] <= d_side.sgn[i] ? -$signed(NW'(qn[i])) : $signed(NW'(qn[i]));
      end
      // With both masses zero each body takes half.
      w1_0 <= $signed(d_side.tot_zero ? W_HALF : NW'(qw1));
      w2_0 <= $signed(d_side.tot_zero ? W_HALF : NW'(qw2));
      pay0 <= d_side.pay;
    end
    if (rdy[D0+1]) begin
      prod <= prod_next;
      n1   <= n0;
      w1_1 <= w1_0;
      w2_1 <= w2_0;
      pay1 <= pay0;
    end
    if (rdy[D0+2]) begin
      dot2 <= dsum[SUMW-1:FRAC_BITS];
      n2   <= n1;
      w1_2 <= w1_1;
      w2_2 <= w2_1;
      pay2 <= pay1;
    end
    if (rdy[D0+3]) begin
      j3   <= jp[JPW-1:FRAC_BITS];
      n3   <= n2;
      w1_3 <= w1_2;
      w2_3 <= w2_2;
      pay3 <= pay2;
    end
    if (rdy[D0+4]) begin
      r1_4 <= rp1[RPW-1:FRAC_BITS];
      r2_4 <= rp2[RPW-1:FRAC_BITS];
      n4   <= n3;
      pay4 <= pay3;
    end
    if (rdy[D0+5]) begin
      for (int i = 0; i < 3; i++) begin
        rn1[i]  <= np1[i][NPW-1:FRAC_BITS];
        rn2[i]  <= np2[i][NPW-1:FRAC_BITS];
        push[i] <= gp[i][GPW-1:FRAC_BITS];
      end
      pay5 <= pay4;
    end
    if (rdy[D0+6]) begin
      result.new_first_vel_x  <= nv1[0];
      result.new_first_vel_y  <= nv1[1];
      result.new_first_vel_z  <= nv1[2];
      result.new_second_vel_x <= nv2[0];
      result.new_second_vel_y <= nv2[1];
      result.new_second_vel_z <= nv2[2];
      result.degenerate       <= pay5.degen;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for two_body_collision_response. A directed table
// and random colliding pairs are streamed under several register settings. Each
// accepted pair with no stored response goes through an in-bench impulse predictor;
// every result beat is compared field by field with the oldest expected response.
// ----------------------------------------------------------------------------
module tb_top;
  import cbr_pkg::*;

  localparam int  FRAC       = 16;
  localparam int  LATENCY    = 42 + FRAC;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  NUM_PHASES = 7;
  localparam int  RAND_PER_PHASE = 100;
  localparam int  NUM_DIR    = 14;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE   = 32'h0001_0000;

  typedef struct packed {
    cbr_item_t   pair;
    logic        typed;
    cbr_result_t resp;
  } pair_row_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  cbr_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  cbr_result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RESTITUTION;
  logic [CFG_W-1:0] cfg_data = '0;

  two_body_collision_response #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copies of the two registers.
  logic [CFG_W-1:0] shadow_rest = 17'd65536;
  logic [CFG_W-1:0] shadow_push = 17'd16384;

  pair_row_t   pair_q[$];
  cbr_result_t response_q[$];
  pair_row_t   cur_row = '0;
  pair_row_t   dir_tab[NUM_DIR];
  int err_cnt = 0;
  int pairs_in = 0;
  int beats_out = 0;
  int degen_out = 0;
  int settings_run = 0;
  int cycle_cnt = 0;

  task automatic add_pair(pair_row_t row);
    pair_q.insert(pair_q.size(), row);
  endtask

  task automatic add_expected(cbr_result_t r);
    response_q.insert(response_q.size(), r);
  endtask

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'h1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_q(longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return S_MAX;
    if (x < -longint'(64'h8000_0000)) return S_MIN;
    return x[31:0];
  endfunction

  function automatic cbr_result_t predict_response(cbr_item_t p, logic [CFG_W-1:0] rest,
                                                   logic [CFG_W-1:0] gain);
    cbr_result_t r;
    longint o[3], a[3], b[3], nrm[3];
    longint unsigned sq, len, mag, q, mm, bm, tot, ee;
    longint w1, w2, d, c, j, g, r1, r2, push;
    logic [31:0] n1[3], n2[3];
    o[0] = longint'(p.offset_x);     o[1] = longint'(p.offset_y);
    o[2] = longint'(p.offset_z);
    a[0] = longint'(p.first_vel_x);  a[1] = longint'(p.first_vel_y);
    a[2] = longint'(p.first_vel_z);
    b[0] = longint'(p.second_vel_x); b[1] = longint'(p.second_vel_y);
    b[2] = longint'(p.second_vel_z);
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(o[i] * o[i]);
    if (sq == 0) begin
      r = {p.first_vel_x, p.first_vel_y, p.first_vel_z,
           p.second_vel_x, p.second_vel_y, p.second_vel_z, 1'b1};
      return r;
    end
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      mag = (o[i] < 0) ? longint'(-o[i]) : longint'(o[i]);
      q = (mag << FRAC) / len;
      nrm[i] = (o[i] < 0) ? -longint'(q) : longint'(q);
    end
    mm = longint'(p.first_mass);
    bm = longint'(p.second_mass);
    tot = mm + bm;
    if (tot == 0) begin
      // Two massless bodies split the change evenly.
      w1 = longint'(1) << (FRAC - 1);
      w2 = w1;
    end else begin
      w1 = longint'((bm << FRAC) / tot);
      w2 = longint'((mm << FRAC) / tot);
    end
    d = 0;
    for (int i = 0; i < 3; i++) d += (a[i] - b[i]) * nrm[i];
    d = d >>> FRAC;
    ee = longint'(rest);
    if (ee > (64'h1 << FRAC)) ee = 64'h1 << FRAC;
    c = (longint'(1) << FRAC) + longint'(ee);
    j = (d * c) >>> FRAC;
    g = longint'(gain);
    r1 = (j * w1) >>> FRAC;
    r2 = (j * w2) >>> FRAC;
    for (int i = 0; i < 3; i++) begin
      push = (g * nrm[i]) >>> FRAC;
      n1[i] = clamp_q(a[i] - ((r1 * nrm[i]) >>> FRAC) - push);
      n2[i] = clamp_q(b[i] + ((r2 * nrm[i]) >>> FRAC) + push);
    end
    r = {n1[0], n1[1], n1[2], n2[0], n2[1], n2[2], 1'b0};
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 11))
      0: return ($urandom_range(0, 3) == 0) ? 31'd0 : 31'd1;
      1: return 31'h7FFF_FFFF;
      2, 3, 4: return 31'($urandom_range(1, 16) << FRAC);
      5: return 31'($urandom_range(1, 32'h0001_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic cbr_item_t rand_pair();
    cbr_item_t p;
    p.offset_x = rand_word();
    p.offset_y = rand_word();
    p.offset_z = rand_word();
    case ($urandom_range(0, 14))
      0: {p.offset_x, p.offset_y, p.offset_z} = '0;
      1: {p.offset_y, p.offset_z} = '0;
      2: p.offset_x = '0;
      default: ;
    endcase
    p.first_vel_x = rand_word();
    p.first_vel_y = rand_word();
    p.first_vel_z = rand_word();
    p.second_vel_x = rand_word();
    p.second_vel_y = rand_word();
    p.second_vel_z = rand_word();
    p.first_mass = rand_mass();
    p.second_mass = rand_mass();
    return p;
  endfunction

  function automatic pair_row_t mk_row(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                       logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                       logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                       logic [30:0] m1, logic [30:0] m2);
    pair_row_t row;
    row.pair = {ox, oy, oz, ax, ay, az, bx, by, bz, m1, m2};
    row.typed = 1'b0;
    row.resp = '0;
    return row;
  endfunction

  // Stimulus driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pair_q.size() > 0) begin
        cur_row <= pair_q[0];
        item <= pair_q[0].pair;
        void'(pair_q.pop_front());
        item_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Accepted pairs feed the expected-response store.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      pairs_in++;
      if (cur_row.typed) add_expected(cur_row.resp);
      else add_expected(predict_response(cur_row.pair, shadow_rest, shadow_push));
    end
  end

  // Receiver stall pattern: the stall rate is redrawn at random from 0, 20, 50 and 85 percent.
  int stall_pct = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 256 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 20;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    result_stall <= ($urandom_range(0, 99) < stall_pct);
    if (cycle_cnt > CYCLE_CAP) begin
      $display("%0t: timeout with %0d responses outstanding", $time, response_q.size());
      $display("two_body_collision_response regression: fail");
      $finish;
    end
  end

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    cbr_result_t want;
    if (!rst && result_valid && !result_stall) begin
      beats_out++;
      if (response_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, actual %h", $time, result);
      end else begin
        want = response_q.pop_front();
        cmp_field("new_first_vel_x", want.new_first_vel_x, result.new_first_vel_x);
        cmp_field("new_first_vel_y", want.new_first_vel_y, result.new_first_vel_y);
        cmp_field("new_first_vel_z", want.new_first_vel_z, result.new_first_vel_z);
        cmp_field("new_second_vel_x", want.new_second_vel_x, result.new_second_vel_x);
        cmp_field("new_second_vel_y", want.new_second_vel_y, result.new_second_vel_y);
        cmp_field("new_second_vel_z", want.new_second_vel_z, result.new_second_vel_z);
        cmp_field("degenerate", 32'(want.degenerate), 32'(result.degenerate));
        if (result.degenerate) degen_out++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_RESTITUTION) shadow_rest = val;
    else shadow_push = val;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pair_q.size() > 0 || item_valid || response_q.size() > 0) @(posedge clk);
  endtask

  logic [CFG_W-1:0] rest_tab[NUM_PHASES];
  logic [CFG_W-1:0] push_tab[NUM_PHASES];

  initial begin
    rest_tab = '{17'd65536, 17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd0, 17'd65536};
    push_tab = '{17'd16384, 17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd0, 17'd16384};
    rest_tab[5] = 17'($urandom_range(0, 65536));
    push_tab[5] = 17'($urandom_range(0, 131071));

    // Zero offset: velocities pass through untouched.
    dir_tab[0] = mk_row(0, 0, 0, S_MAX, S_MIN, 0, S_MIN, S_MAX, 1, 1, 1);
    dir_tab[0].typed = 1'b1;
    dir_tab[0].resp = {S_MAX, S_MIN, 32'd0, S_MIN, S_MAX, 32'd1, 1'b1};
    dir_tab[0].resp.degenerate = 1'b1;
    // Bodies at rest along x: only the default push-out acts.
    dir_tab[1] = mk_row(ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE[30:0], ONE[30:0]);
    dir_tab[1].typed = 1'b1;
    dir_tab[1].resp = {-32'sd16384, 32'd0, 32'd0, 32'd16384, 32'd0, 32'd0, 1'b0};
    dir_tab[2] = mk_row(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    dir_tab[2].typed = 1'b1;
    dir_tab[2].resp = {32'd16384, 32'd0, 32'd0, -32'sd16384, 32'd0, 32'd0, 1'b0};
    dir_tab[3] = mk_row(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF);
    dir_tab[4] = mk_row(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 1, 1);
    dir_tab[5] = mk_row(ONE, 0, 0, ONE, 0, 0, -ONE, 0, 0, ONE[30:0], ONE[30:0]);
    dir_tab[6] = mk_row(0, ONE, 0, 0, 32'h0003_0000, 0, 0, 0, 0, 31'h7FFF_FFFF, 1);
    // Two massless bodies, then one massless body.
    dir_tab[7] = mk_row(0, 0, ONE, 0, 0, ONE, 0, 0, 0, 0, 0);
    dir_tab[8] = mk_row(ONE, ONE, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE[30:0]);
    dir_tab[9] = mk_row(ONE, 0, 0, S_MIN, 0, 0, S_MAX, 0, 0, ONE[30:0], 0);
    dir_tab[10] = mk_row(ONE, ONE, ONE, 32'h0002_0000, 32'hFFFF_0000, 0,
                         32'hFFFE_0000, 32'h0001_0000, ONE, 31'h0002_0000, ONE[30:0]);
    dir_tab[11] = mk_row(0, 0, 1, 0, 0, S_MAX, 0, 0, S_MIN, 5, 7);
    dir_tab[12] = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[12].typed = 1'b1;
    dir_tab[12].resp = {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    dir_tab[13] = mk_row(32'h7FFF_0000, 32'h8001_0000, 0, 32'h1234_5678, 32'hEDCB_A988,
                         32'h0F0F_0F0F, 32'hF0F0_F0F1, 32'h5555_5555, 32'hAAAA_AAAA,
                         31'h2AAA_AAAA, 31'h5555_5555);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        write_reg(REG_RESTITUTION, rest_tab[ph]);
        write_reg(REG_PUSH_GAIN, push_tab[ph]);
      end else begin
        for (int k = 0; k < NUM_DIR; k++) add_pair(dir_tab[k]);
      end
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        pair_row_t row;
        row.pair = rand_pair();
        row.typed = 1'b0;
        row.resp = '0;
        add_pair(row);
      end
      drain();
      settings_run++;
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Ran %0d pairs over %0d register settings; %0d response beats, %0d degenerate.",
             pairs_in, settings_run, beats_out, degen_out);
    $display("Mismatches or stray beats: %0d, responses left over: %0d.",
             err_cnt, response_q.size());
    if (err_cnt == 0 && response_q.size() == 0) begin
      $display("two_body_collision_response regression: pass");
    end else begin
      $display("two_body_collision_response regression: fail");
    end
    $finish;
  end

endmodule
